[hw/rtl/jac_pkg.sv]
// Package: shared types and constants for the joystick axis calibration block.
package jac_pkg;

  typedef enum logic [1:0] {
    PH_OFF   = 2'd0,
    PH_TRACK = 2'd1,
    PH_END   = 2'd2,
    PH_SPARE = 2'd3
  } cal_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRACK,
    ST_DIVN,
    ST_DIVP,
    ST_MUL,
    ST_OUT
  } seq_state_t;

endpackage

[hw/rtl/jac_divider.sv]
// Restoring divider: one quotient bit per cycle, unsigned.
module jac_divider #(
  parameter int NumW = 40,
  parameter int DenW = 20
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [NumW-1:0] quo
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q;
  logic [DenW:0]   rem;
  logic [DenW-1:0] d;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DenW:0]   trial;

  assign trial = {rem[DenW-1:0], q[NumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(NumW);
        q    <= num;
        rem  <= '0;
        d    <= den;
      end else if (busy) begin
        // shift in one numerator bit, subtract where it fits
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q   <= {q[NumW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;
endmodule

[hw/rtl/joystick_axis_calibration_unit.sv]
// Top level: joystick axis calibration with tracker, gain division and applied scaling.
//
// Usage: one request on the s_axis channel gives one result on m_axis.
// s_axis_tdata: heading (17b signed, fixed point), cal_switch, button_port.
// m_axis_tdata: axis_value (int8), buttons (inverted port), calibrating.
// Each request runs through a small sequencer: a tracking state, then a
// multiply state and an output register. The sample that ends calibration
// also runs the shared restoring divider twice (gain_negative then
// gain_positive), one quotient bit per cycle, between the tracking and
// multiply states.
// s_axis_tready is high only in the idle state; the block works on one
// request at a time. The result waits in the output register while the
// receiver stalls, and no new request is taken until it goes.
// Reset (synchronous, active high) clears the tracker, sets both gains to
// 1.0 and the centre offset to zero, and leaves the block idle.
module joystick_axis_calibration_unit
  import jac_pkg::*;
#(
  parameter int HEADING_FRAC_BITS = 8,
  parameter int GAIN_FRAC_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // heading[16:0], cal_switch[17], button_port[25:18]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // axis_value[7:0], buttons[15:8], calibrating[16]
);
  localparam int HF   = HEADING_FRAC_BITS;
  localparam int GF   = GAIN_FRAC_BITS;
  localparam int GW   = 8 + GF;
  localparam int VW   = HF + 11;        // wide enough for wrapped sums
  localparam int NUMW = 8 + HF + GF + 1;
  localparam int PW   = VW + GW + 1;

  localparam logic signed [VW-1:0] ONE   = VW'(1) <<< HF;
  localparam logic signed [VW-1:0] P128  = ONE * 128;
  localparam logic signed [VW-1:0] P256  = ONE * 256;
  localparam logic signed [VW-1:0] P96   = ONE * 96;
  localparam logic signed [VW-1:0] P64   = ONE * 64;
  localparam logic [GW-1:0]        GMAX  = '1;
  localparam logic [NUMW-1:0]      NUM   = NUMW'(128) << (HF + GF);

  seq_state_t state, state_next;
  cal_phase_t phase, phase_next;

  logic signed [16:0] heading;
  logic               sw;
  logic [7:0]         btn;
  logic signed [7:0]  tmin, tmax, toff;
  logic signed [19:0] centre;
  logic [GW-1:0]      gneg, gpos;
  logic               led, led_next;
  logic signed [VW-1:0] dneg, dpos;

  // tracker combinational path
  logic signed [VW-1:0] v0, v1, v2, vmin, vmax, dneg_c, dpos_c;
  logic signed [7:0]    toff1, tmin1, tmax1, v_i8;
  logic signed [7:0]    toff_next, tmin_next, tmax_next;

  function automatic logic signed [VW-1:0] wrapr(input logic signed [VW-1:0] x);
    logic signed [VW-1:0] y;
    y = x;
    if (y < -P128) y = y + P256;
    if (y > P128)  y = y - P256;
    return y;
  endfunction

  function automatic logic signed [7:0] to_i8(input logic signed [VW-1:0] x);
    logic signed [VW-1:0] t;
    t = (x < 0) ? -((-x) >>> HF) : (x >>> HF);
    return t[7:0];
  endfunction

  always_comb begin
    v0 = wrapr(VW'(heading) + (VW'(toff) <<< HF));
    toff1 = toff; tmin1 = tmin; tmax1 = tmax; v1 = v0;
    if (v0 < -P96) begin
      toff1 = toff + 8'sd64; tmin1 = tmin + 8'sd64; tmax1 = tmax + 8'sd64;
      v1 = v0 + P64;
    end else if (v0 > P96) begin
      toff1 = toff - 8'sd64; tmin1 = tmin - 8'sd64; tmax1 = tmax - 8'sd64;
      v1 = v0 - P64;
    end
    v_i8 = to_i8(v1);
    vmin = VW'(tmin1) <<< HF;
    vmax = VW'(tmax1) <<< HF;
    v2 = v1;
    dneg_c = vmin - v2;
    dpos_c = vmax - v2;
    // advance the tracker phase
    phase_next = phase; led_next = led;
    toff_next = toff1; tmin_next = tmin1; tmax_next = tmax1;
    unique case (phase)
      PH_TRACK: begin
        if (!sw) phase_next = PH_END;
        if (vmin > v2) tmin_next = v_i8;
        if (vmax < v2) tmax_next = v_i8;
      end
      PH_END: begin
        led_next = 1'b0;
        tmin_next = '0; tmax_next = '0; toff_next = '0;
        phase_next = PH_OFF;
      end
      default: if (sw) begin
        led_next = 1'b1;
        tmin_next = v_i8; tmax_next = v_i8; toff_next = '0;
        phase_next = PH_TRACK;
      end
    endcase
  end

  // divider share
  logic             div_start, div_done;
  logic [NUMW-1:0]  div_q;
  logic [VW-1:0]    div_den;
  jac_divider #(.NumW(NUMW), .DenW(VW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(NUM), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  // applied path
  logic signed [VW-1:0] r;
  logic signed [PW-1:0] prod;
  logic signed [7:0]    axis, axis_next;

  always_comb begin
    r = wrapr(VW'(heading) + VW'(centre));
    prod = PW'(r) * $signed({1'b0, (r < 0) ? gneg : gpos});
    if (prod < -(PW'(128) <<< (HF + GF))) axis_next = -8'sd128;
    else if (prod > (PW'(127) <<< (HF + GF))) axis_next = 8'sd127;
    else if (prod < 0) axis_next = 8'(-((-prod) >>> (HF + GF)));
    else axis_next = 8'(prod >>> (HF + GF));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_axis_tvalid) state_next = ST_TRACK;
      ST_TRACK: state_next = (phase == PH_END) ? ST_DIVN : ST_MUL;
      ST_DIVN:  if (div_done) state_next = ST_DIVP;
      ST_DIVP:  if (div_done) state_next = ST_MUL;
      ST_MUL:   state_next = ST_OUT;
      ST_OUT:   if (m_axis_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = (state == ST_OUT);
    div_start = ((state == ST_TRACK) && (phase == PH_END)) ||
                ((state == ST_DIVN) && div_done);
    div_den = (state == ST_TRACK) ? -dneg_c : dpos;
  end

  function automatic logic [GW-1:0] sat(input logic [NUMW-1:0] q);
    return (q > NUMW'(GMAX)) ? GMAX : q[GW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_OFF;
      tmin <= '0; tmax <= '0; toff <= '0;
      centre <= '0;
      gneg <= GW'(1) << GF;
      gpos <= GW'(1) << GF;
      led <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          heading <= s_axis_tdata[16:0];
          sw      <= s_axis_tdata[17];
          btn     <= s_axis_tdata[25:18];
        end
        ST_TRACK: begin
          toff <= toff_next; tmin <= tmin_next; tmax <= tmax_next;
          phase <= phase_next;
          led <= led_next;
          if (phase == PH_END) begin
            centre <= 20'((VW'(toff1) <<< HF) - v2);
            dneg <= dneg_c;
            dpos <= dpos_c;
            // trivial cases settled now; divider refines others
            if (dneg_c == 0) gneg <= GMAX;
            else if (dneg_c > 0) gneg <= '0;
            if (dpos_c == 0) gpos <= GMAX;
            else if (dpos_c < 0) gpos <= '0;
          end
        end
        ST_DIVN: if (div_done && dneg < 0) gneg <= sat(div_q);
        ST_DIVP: if (div_done && dpos > 0) gpos <= sat(div_q);
        ST_MUL: axis <= axis_next;
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = {7'd0, led, ~btn, axis};
endmodule

[hw/rtl/jac_checker.sv]
// Checker: port-level properties of the calibration block, bound to the top level.
module jac_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  a_no_both: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:17] == 7'd0) else $error("padding set");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("took two");
endmodule

bind joystick_axis_calibration_unit jac_checker u_chk (.*);

[sim/testbench.sv]
// Testbench for the joystick axis calibration unit: predicts each sample and checks results.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import jac_pkg::*;

  localparam int HFB = 8;
  localparam int GFB = 16;
  localparam longint HUNIT = 64'sd1 << HFB;
  localparam longint GAIN_TOP = (64'sd1 << (8 + GFB)) - 1;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] axis;
    logic [7:0] btn;
    logic       cal;
  } axis_result_t;

  // Mirror of the calibration state; predicts one result per sample.
  class calibration_scoreboard;
    cal_phase_t     phase;
    int             tmin, tmax, toff;
    longint         centre;
    longint         gneg, gpos;
    bit             led;
    axis_result_t   pending[$];
    int             errors;

    function new();
      phase = PH_OFF; tmin = 0; tmax = 0; toff = 0; centre = 0;
      gneg = 64'sd1 << GFB; gpos = 64'sd1 << GFB; led = 0; errors = 0;
    endfunction

    function int wrap_byte(longint x);
      logic [7:0] b;
      b = x[7:0];
      return $signed(b);
    endfunction

    function longint fold(longint r);
      if (r < -128 * HUNIT) r += 256 * HUNIT;
      if (r > 128 * HUNIT) r -= 256 * HUNIT;
      return r;
    endfunction

    function longint gain_of(longint d, bit neg_side);
      longint mag, q;
      if (d == 0) return GAIN_TOP;
      if (neg_side ? d > 0 : d < 0) return 0;
      mag = d < 0 ? -d : d;
      q = (64'sd128 << (HFB + GFB)) / mag;
      return q > GAIN_TOP ? GAIN_TOP : q;
    endfunction

    function void note_request(logic [16:0] hd, logic sw, logic [7:0] port);
      longint h, v, r, p, s;
      logic [19:0] c20;
      axis_result_t res;
      h = longint'($signed(hd));
      v = fold(h + toff * HUNIT);
      if (v < -96 * HUNIT) begin
        toff = wrap_byte(toff + 64); tmin = wrap_byte(tmin + 64);
        tmax = wrap_byte(tmax + 64); v += 64 * HUNIT;
      end else if (v > 96 * HUNIT) begin
        toff = wrap_byte(toff - 64); tmin = wrap_byte(tmin - 64);
        tmax = wrap_byte(tmax - 64); v -= 64 * HUNIT;
      end
      if (phase == PH_TRACK) begin
        if (!sw) phase = PH_END;
        if (tmin * HUNIT > v) tmin = wrap_byte(v / HUNIT);
        if (tmax * HUNIT < v) tmax = wrap_byte(v / HUNIT);
      end else if (phase == PH_END) begin
        led = 0;
        c20 = 20'(toff * HUNIT - v);
        centre = longint'($signed(c20));
        gneg = gain_of(tmin * HUNIT - v, 1);
        gpos = gain_of(tmax * HUNIT - v, 0);
        tmin = 0; tmax = 0; toff = 0; phase = PH_OFF;
      end else if (sw) begin
        led = 1; tmin = wrap_byte(v / HUNIT); tmax = tmin; toff = 0; phase = PH_TRACK;
      end
      r = fold(h + centre);
      p = r * (r < 0 ? gneg : gpos);
      s = 64'sd1 << (HFB + GFB);
      if (p < -128 * s) res.axis = 8'h80;
      else if (p > 127 * s) res.axis = 8'h7f;
      else res.axis = 8'(p / s);
      res.btn = ~port;
      res.cal = led;
      pending.push_back(res);
    endfunction

    function void check_result(logic [23:0] data);
      axis_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (data[7:0] !== want.axis) begin
        $display("%0t: axis_value expected %0d actual %0d", $time,
                 $signed(want.axis), $signed(data[7:0]));
        errors++;
      end
      if (data[15:8] !== want.btn) begin
        $display("%0t: buttons expected %h actual %h", $time, want.btn, data[15:8]);
        errors++;
      end
      if (data[16] !== want.cal) begin
        $display("%0t: calibrating expected %b actual %b", $time, want.cal, data[16]);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [23:0] m_axis_tdata;

  calibration_scoreboard board;
  int idle_pct, stall_pct, quiet_cycles;

  joystick_axis_calibration_unit i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall at random, check every accepted result.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: count cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Send one request and hold it until accepted; idle cycles drop valid.
  task automatic send_sample(logic [16:0] hd, logic sw, logic [7:0] port);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, port, sw, hd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_request(hd, sw, port);
  endtask

  function automatic logic [16:0] any_heading();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 17'($urandom);
    if (k == 1) return 17'($urandom_range(65536) - 32768);
    return 17'(int'($urandom_range(30000)) - 15000);
  endfunction

  // One calibration pass: switch on, sweep, release, ending sample.
  task automatic calibrate_sweep(int len);
    send_sample(any_heading(), 1'b1, 8'($urandom));
    repeat (len) send_sample(any_heading(), 1'b1, 8'($urandom));
    send_sample(any_heading(), 1'b0, 8'($urandom));
    send_sample(any_heading(), 1'($urandom_range(1)), 8'($urandom));
  endtask

  task automatic run_phase(int idle, int stall, int count);
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) begin
      if ($urandom_range(3) == 0) calibrate_sweep($urandom_range(12));
      else send_sample(any_heading(), $urandom_range(7) == 0, 8'($urandom));
    end
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, wraps, recentring, zero-divisor and negative-quotient gains.
    send_sample(17'h10000, 1'b0, 8'h00);
    send_sample(17'h08000, 1'b0, 8'hff);
    send_sample(17'h0ffff, 1'b0, 8'h55);
    send_sample(17'h18000, 1'b0, 8'haa);
    send_sample(17'h00000, 1'b1, 8'h0f);  // start: min = max = 0
    send_sample(17'h00000, 1'b0, 8'hf0);  // release
    send_sample(17'h00000, 1'b0, 8'h01);  // end with zero divisors
    send_sample(17'h07f00, 1'b0, 8'h80);
    send_sample(17'h18100, 1'b0, 8'h7f);
    send_sample(17'h06200, 1'b1, 8'h12);  // past +96 recentres
    send_sample(17'h19c00, 1'b1, 8'h34);  // past -96 recentres
    send_sample(17'h00180, 1'b1, 8'h56);
    send_sample(17'h1ff80, 1'b0, 8'h78);
    send_sample(17'h05000, 1'b1, 8'h9a);  // ending, switch ignored
    send_sample(17'h00100, 1'b1, 8'hbc);  // start
    send_sample(17'h00800, 1'b0, 8'hde);  // max above, release
    send_sample(17'h1f000, 1'b0, 8'h21);  // ending: negative quotient
    send_sample(17'h00001, 1'b0, 8'h43);
    send_sample(17'h1ffff, 1'b0, 8'h65);

    run_phase(0, 0, 120);
    run_phase(75, 0, 80);
    run_phase(0, 75, 80);
    run_phase(28, 28, 120);
    run_phase(0, 0, 80);
    s_axis_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

[files.f]
hw/rtl/jac_pkg.sv
hw/rtl/jac_divider.sv
hw/rtl/joystick_axis_calibration_unit.sv
hw/rtl/jac_checker.sv
sim/testbench.sv
